// ----- hw/rtl/pvr_pkg.sv -----
// Package for the planar vector rotator: widths, gain constant and
// arctangent table shared by the top level and its pipeline stages.
// No dependencies.
`default_nettype none

package pvr_pkg;

   localparam int DATA_WIDTH_DEF      = 16;
   localparam int ROTATION_STAGES_DEF = 16;
   localparam int GUARD_BITS          = 24;
   localparam int ANGLE_BITS          = 32;
   localparam int ATAN_ENTRIES        = 32;
   localparam int Z_WIDTH             = ANGLE_BITS + 2;

   localparam logic [31:0] GAIN_INV_Q32 = 32'd2608131496;
   localparam logic [Z_WIDTH-1:0] QUARTER_TURN = Z_WIDTH'(64'd1073741824);

   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

`default_nettype wire

// ----- hw/rtl/pvr_stage.sv -----
// One CORDIC micro-rotation stage with its output register and valid bit.
// Depends on pvr_pkg.
`default_nettype none

module pvr_stage #(
   parameter int          XW    = 42,
   parameter int          SHIFT = 0,
   parameter logic [31:0] ATAN  = '0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic signed [XW-1:0]             in_x,
   input  wire logic signed [XW-1:0]             in_y,
   input  wire logic signed [pvr_pkg::Z_WIDTH-1:0] in_z,
   output logic                                  out_valid_ff,
   output logic signed [XW-1:0]                  out_x_ff,
   output logic signed [XW-1:0]                  out_y_ff,
   output logic signed [pvr_pkg::Z_WIDTH-1:0]    out_z_ff
);
   import pvr_pkg::*;

   logic signed [XW-1:0]      dx;
   logic signed [XW-1:0]      dy;
   logic signed [Z_WIDTH-1:0] step;
   logic signed [XW-1:0]      x_in;
   logic signed [XW-1:0]      y_in;
   logic signed [Z_WIDTH-1:0] z_in;

   always_comb begin
      dx   = in_y >>> SHIFT;
      dy   = in_x >>> SHIFT;
      step = $signed({{(Z_WIDTH-32){1'b0}}, ATAN});
      if (!in_z[Z_WIDTH-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - step;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_x_ff <= x_in;
         out_y_ff <= y_in;
         out_z_ff <= z_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/pvr_gain.sv -----
// Gain compensation, rounding and saturation for both vector components,
// four register stages with valid bits. Depends on pvr_pkg.
`default_nettype none

module pvr_gain #(
   parameter int DATA_WIDTH = pvr_pkg::DATA_WIDTH_DEF,
   parameter int XW         = 42
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire logic signed [XW-1:0]         in_x,
   input  wire logic signed [XW-1:0]         in_y,
   output logic                              out_valid,
   output logic signed [DATA_WIDTH-1:0]      out_x,
   output logic signed [DATA_WIDTH-1:0]      out_y,
   output logic                              out_saturated
);
   import pvr_pkg::*;

   localparam int RW = DATA_WIDTH + 2;
   localparam logic signed [RW-1:0] MAX_V = {3'b000, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_V = {3'b111, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [XW:0] ROUND_ONE = (XW+1)'(1) << (GUARD_BITS - 1);

   logic [3:0] valid_ff;

   logic signed [XW-1:0] comp [2];

   logic                        neg1_ff [2];
   logic [XW-1:0]               mag1_ff [2];
   logic                        neg2_ff [2];
   logic [63:0]                 plo2_ff [2];
   logic [XW-1:0]               phi2_ff [2];
   logic signed [RW-1:0]        res3_ff [2];
   logic signed [DATA_WIDTH-1:0] out4_ff [2];
   logic                        sat4_ff [2];

   assign comp[0] = in_x;
   assign comp[1] = in_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   for (genvar c = 0; c < 2; c++) begin : g_comp
      logic [XW-1:0]        mag_in;
      logic [XW:0]          sum;
      logic [XW:0]          rnd;
      logic [DATA_WIDTH:0]  r;
      logic signed [RW-1:0] res_in;
      logic signed [DATA_WIDTH-1:0] out_in;
      logic                 sat_in;

      always_comb begin
         mag_in = comp[c][XW-1] ? XW'(-comp[c]) : XW'(comp[c]);
         sum    = {1'b0, phi2_ff[c]} + (XW+1)'(plo2_ff[c][63:32]);
         rnd    = sum + ROUND_ONE;
         r      = rnd[GUARD_BITS +: DATA_WIDTH+1];
         res_in = neg2_ff[c] ? -$signed({1'b0, r}) : $signed({1'b0, r});
         if (res3_ff[c] > MAX_V) begin
            out_in = MAX_V[DATA_WIDTH-1:0];
            sat_in = 1'b1;
         end else if (res3_ff[c] < MIN_V) begin
            out_in = MIN_V[DATA_WIDTH-1:0];
            sat_in = 1'b1;
         end else begin
            out_in = res3_ff[c][DATA_WIDTH-1:0];
            sat_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            neg1_ff[c] <= comp[c][XW-1];
            mag1_ff[c] <= mag_in;
            neg2_ff[c] <= neg1_ff[c];
            plo2_ff[c] <= 64'(mag1_ff[c][31:0]) * 64'(GAIN_INV_Q32);
            phi2_ff[c] <= XW'(mag1_ff[c][XW-1:32]) * XW'(GAIN_INV_Q32);
            res3_ff[c] <= res_in;
            out4_ff[c] <= out_in;
            sat4_ff[c] <= sat_in;
         end
      end
   end

   assign out_valid     = valid_ff[3];
   assign out_x         = out4_ff[0];
   assign out_y         = out4_ff[1];
   assign out_saturated = sat4_ff[0] | sat4_ff[1];

endmodule

`default_nettype wire

// ----- hw/rtl/planar_vector_rotator.sv -----
// Planar vector rotator: CORDIC rotation with one register per micro-rotation.
// Registers: quarter-turn stage, one per CORDIC stage (at most ATAN_ENTRIES),
// four for gain, rounding and saturation; one item per cycle unless stalled.
// The whole pipeline holds while a finished item waits on rsp_stall.
// Synchronous active-high reset clears all valid bits; data needs no reset.
// Depends on pvr_pkg, pvr_stage and pvr_gain.
`default_nettype none

module planar_vector_rotator #(
   parameter int DATA_WIDTH      = pvr_pkg::DATA_WIDTH_DEF,
   parameter int ROTATION_STAGES = pvr_pkg::ROTATION_STAGES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_in,
   input  wire logic signed [DATA_WIDTH-1:0] req_y_in,
   input  wire logic signed [DATA_WIDTH-1:0] req_angle,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_x_out,
   output logic signed [DATA_WIDTH-1:0]      rsp_y_out,
   output logic                              rsp_saturated
);
   import pvr_pkg::*;

   localparam int XW  = DATA_WIDTH + GUARD_BITS + 2;
   localparam int STG = (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STAGES;
   localparam int ZSHIFT = ANGLE_BITS - DATA_WIDTH;

   logic advance;

   logic                      valid_pipe [STG+1];
   logic signed [XW-1:0]      x_pipe     [STG+1];
   logic signed [XW-1:0]      y_pipe     [STG+1];
   logic signed [Z_WIDTH-1:0] z_pipe     [STG+1];

   logic signed [XW-1:0]      x_ext;
   logic signed [XW-1:0]      y_ext;
   logic signed [Z_WIDTH-1:0] z_ext;
   logic signed [XW-1:0]      x0_in;
   logic signed [XW-1:0]      y0_in;
   logic signed [Z_WIDTH-1:0] z0_in;

   logic                      valid0_ff;
   logic signed [XW-1:0]      x0_ff;
   logic signed [XW-1:0]      y0_ff;
   logic signed [Z_WIDTH-1:0] z0_ff;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      x_ext = XW'(req_x_in) <<< GUARD_BITS;
      y_ext = XW'(req_y_in) <<< GUARD_BITS;
      z_ext = Z_WIDTH'(req_angle) <<< ZSHIFT;
      if (z_ext > $signed(QUARTER_TURN)) begin
         x0_in = -y_ext;
         y0_in = x_ext;
         z0_in = z_ext - $signed(QUARTER_TURN);
      end else if (z_ext < -$signed(QUARTER_TURN)) begin
         x0_in = y_ext;
         y0_in = -x_ext;
         z0_in = z_ext + $signed(QUARTER_TURN);
      end else begin
         x0_in = x_ext;
         y0_in = y_ext;
         z0_in = z_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         z0_ff <= z0_in;
      end
   end

   assign valid_pipe[0] = valid0_ff;
   assign x_pipe[0]     = x0_ff;
   assign y_pipe[0]     = y0_ff;
   assign z_pipe[0]     = z0_ff;

   for (genvar i = 0; i < STG; i++) begin : g_stage
      pvr_stage #(
         .XW    (XW),
         .SHIFT (i),
         .ATAN  (ATAN_TABLE[i])
      ) u_stage (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .in_valid     (valid_pipe[i]),
         .in_x         (x_pipe[i]),
         .in_y         (y_pipe[i]),
         .in_z         (z_pipe[i]),
         .out_valid_ff (valid_pipe[i+1]),
         .out_x_ff     (x_pipe[i+1]),
         .out_y_ff     (y_pipe[i+1]),
         .out_z_ff     (z_pipe[i+1])
      );
   end

   pvr_gain #(
      .DATA_WIDTH (DATA_WIDTH),
      .XW         (XW)
   ) u_gain (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .in_valid      (valid_pipe[STG]),
      .in_x          (x_pipe[STG]),
      .in_y          (y_pipe[STG]),
      .out_valid     (rsp_valid),
      .out_x         (rsp_x_out),
      .out_y         (rsp_y_out),
      .out_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire
